### design/ipv4p_pkg.sv
// Shared types, protocol constants and helpers for the IPv4 header parser.
package ipv4p_pkg;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [6:0] UDP_HDR_BYTES = 7'd8;
	localparam logic [6:0] TCP_MIN_HDR_BYTES = 7'd20;
	localparam logic [3:0] MIN_WORDS = 4'd5;
	localparam logic [15:0] POS_PROTOCOL = 16'd9;
	localparam logic [15:0] POS_SRC_FIRST = 16'd12;
	localparam logic [15:0] POS_SRC_LAST = 16'd15;
	localparam logic [15:0] POS_DST_FIRST = 16'd16;
	localparam logic [15:0] POS_DST_LAST = 16'd19;
	localparam logic [15:0] POS_L4_FIRST = 16'd20;
	localparam logic [15:0] POS_MAX = 16'hFFFF;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic payload_valid;
		logic [7:0] payload_byte;
		logic end_of_packet;
		logic [3:0] ip_version;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [7:0] protocol_number;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] payload_length;
		logic truncated;
	} out_item_t;

	// Header length field in 32-bit words to bytes, with a floor of five words.
	function automatic logic [5:0] words_to_bytes(input logic [3:0] nib);
		logic [3:0] w;
		w = (nib < MIN_WORDS) ? MIN_WORDS : nib;
		return {w, 2'b00};
	endfunction

endpackage

### design/ipv4p_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface ipv4p_chan_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/ipv4p_core.sv
// Per-packet header state and the one-byte parse step.
module ipv4p_core
	import ipv4p_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic step,
	input in_item_t item,
	output logic has_result,
	output out_item_t res
);

	logic [15:0] pos_q;
	logic [5:0] ihl_q;
	logic [6:0] pstart_q;
	logic [3:0] ver_q;
	logic [7:0] prot_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [15:0] count_q;

	logic [15:0] pos_n;
	logic [5:0] ihl_n;
	logic [6:0] pstart_n;
	logic [3:0] ver_n;
	logic [7:0] prot_n;
	logic [31:0] src_n;
	logic [31:0] dst_n;
	logic [15:0] sport_n;
	logic [15:0] dport_n;
	logic [15:0] count_n;

	logic [7:0] b;
	logic [15:0] ihl_w;
	logic [6:0] ihl_7;
	logic is_l4;
	logic payload;

	always_comb begin
		b = item.data_byte;
		ihl_w = {10'd0, ihl_q};
		ihl_7 = {1'b0, ihl_q};
		is_l4 = (prot_q == PROTO_TCP) || (prot_q == PROTO_UDP);

		ver_n = ver_q;
		ihl_n = ihl_q;
		pstart_n = pstart_q;
		prot_n = prot_q;
		src_n = src_q;
		dst_n = dst_q;
		sport_n = sport_q;
		dport_n = dport_q;

		if (pos_q == 16'd0) begin
			ver_n = b[7:4];
			ihl_n = words_to_bytes(b[3:0]);
			pstart_n = {1'b0, ihl_n};
		end else if (pos_q == POS_PROTOCOL) begin
			prot_n = b;
			if (b == PROTO_TCP) begin
				pstart_n = ihl_7 + TCP_MIN_HDR_BYTES;
			end else if (b == PROTO_UDP) begin
				pstart_n = ihl_7 + UDP_HDR_BYTES;
			end else begin
				pstart_n = ihl_7;
			end
		end else if (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) begin
			src_n = {src_q[23:0], b};
		end else if (pos_q >= POS_DST_FIRST && pos_q <= POS_DST_LAST) begin
			dst_n = {dst_q[23:0], b};
		end

		// Transport header fields sit at fixed offsets from the IP header end.
		if (pos_q >= POS_L4_FIRST && is_l4) begin
			if (pos_q == ihl_w || pos_q == ihl_w + 16'd1) begin
				sport_n = {sport_q[7:0], b};
			end else if (pos_q == ihl_w + 16'd2 || pos_q == ihl_w + 16'd3) begin
				dport_n = {dport_q[7:0], b};
			end else if (prot_q == PROTO_TCP && pos_q == ihl_w + 16'd12) begin
				pstart_n = ihl_7 + {1'b0, words_to_bytes(b[7:4])};
			end
		end

		payload = (pos_q >= POS_L4_FIRST) && (pos_q >= {9'd0, pstart_n});
		count_n = (payload && count_q != COUNT_MAX) ? count_q + 16'd1 : count_q;
		pos_n = (pos_q != POS_MAX) ? pos_q + 16'd1 : pos_q;
		has_result = payload || item.last_byte;

		res.payload_valid = payload;
		res.payload_byte = payload ? b : 8'd0;
		res.end_of_packet = item.last_byte;
		res.ip_version = ver_n;
		res.src_address = src_n;
		res.dst_address = dst_n;
		res.protocol_number = prot_n;
		res.src_port = sport_n;
		res.dst_port = dport_n;
		res.payload_length = count_n;
		res.truncated = item.last_byte && (pos_n < {9'd0, pstart_n});
	end

	// Advance on each byte; clear everything after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ihl_q <= '0;
			pstart_q <= '0;
			ver_q <= '0;
			prot_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
			count_q <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				pos_q <= '0;
				ihl_q <= '0;
				pstart_q <= '0;
				ver_q <= '0;
				prot_q <= '0;
				src_q <= '0;
				dst_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
				count_q <= '0;
			end else begin
				pos_q <= pos_n;
				ihl_q <= ihl_n;
				pstart_q <= pstart_n;
				ver_q <= ver_n;
				prot_q <= prot_n;
				src_q <= src_n;
				dst_q <= dst_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
				count_q <= count_n;
			end
		end
	end

endmodule

### design/ipv4_l4_header_parser_unit.sv
// IPv4 / TCP / UDP header parser top level: input register, parse step, result register.
//
//  channel     dir   payload      one item is
//  pkt_bytes   in    in_item_t    one raw packet byte, last_byte on the final one
//  parsed      out   out_item_t   a payload byte or the end-of-packet summary
//
// One byte per clock is accepted unless a byte with a result is held by a blocked output;
// each byte is registered, parsed combinationally in ipv4p_core, and its result registered.
// Header bytes that are not final give no result and never stall.
// The result register holds while parsed.ready is low; one byte waits in the
// input register behind it, then pkt_bytes.ready drops.
// Reset clears all packet state; the same state clears after each final byte.
module ipv4_l4_header_parser_unit
	import ipv4p_pkg::*;
(
	input logic clk,
	input logic arst_n,
	ipv4p_chan_if.sink pkt_bytes,
	ipv4p_chan_if.source parsed
);

	logic valid_s1;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_q;

	logic step;
	logic has_result;
	out_item_t res;

	ipv4p_core u_core (
		.clk (clk),
		.arst_n (arst_n),
		.step (step),
		.item (item_s1),
		.has_result (has_result),
		.res (res)
	);

	// Advance the held byte unless it has a result and the output is blocked.
	assign step = valid_s1 && (!has_result || !out_valid_q || parsed.ready);
	assign pkt_bytes.ready = !valid_s1 || step;
	assign parsed.valid = out_valid_q;
	assign parsed.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_bytes.valid && pkt_bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_bytes.valid && pkt_bytes.ready) begin
			item_s1 <= pkt_bytes.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && has_result) begin
			out_valid_q <= 1'b1;
		end else if (parsed.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_result) begin
			out_q <= res;
		end
	end

endmodule

### tb/sv/tb_ipv4_l4_header_parser_unit.sv
// Testbench for ipv4_l4_header_parser_unit: byte stimulus, parse prediction, field checks.
`timescale 1ns / 100ps

module tb_ipv4_l4_header_parser_unit
	import ipv4p_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 40;
	localparam int PHASE_BYTES = 150;
	localparam int TCP_DOFF_OFFSET = 12;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	logic clk;
	logic arst_n;

	ipv4p_chan_if #(.payload_t(in_item_t)) pkt_bytes_ch ();
	ipv4p_chan_if #(.payload_t(out_item_t)) parsed_ch ();

	ipv4_l4_header_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_bytes(pkt_bytes_ch),
		.parsed(parsed_ch)
	);

	// predicted parser state
	logic [15:0] st_pos;
	logic [6:0] st_ihl;
	logic [6:0] st_start;
	logic [3:0] st_ver;
	logic [7:0] st_proto;
	logic [31:0] st_src;
	logic [31:0] st_dst;
	logic [15:0] st_sport;
	logic [15:0] st_dport;
	logic [15:0] st_count;

	out_item_t parsed_due[$];
	logic [7:0] pkt_buf[$];
	out_item_t want;
	out_item_t got;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int results_seen = 0;
	int payload_results = 0;
	int trunc_ends = 0;
	int packets_sent = 0;
	int bytes_sent = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom;
		return r[7:0];
	endfunction

	// header length nibble in words to bytes, never below five words
	function automatic logic [6:0] hdr_bytes(input logic [3:0] words);
		if (words < MIN_WORDS)
			return {1'b0, MIN_WORDS, 2'b00};
		return {1'b0, words, 2'b00};
	endfunction

	task automatic clear_parse_state();
		st_pos = '0;
		st_ihl = '0;
		st_start = '0;
		st_ver = '0;
		st_proto = '0;
		st_src = '0;
		st_dst = '0;
		st_sport = '0;
		st_dport = '0;
		st_count = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic final_mark);
		logic [15:0] pos;
		logic [6:0] ihl;
		logic l4;
		logic pay;
		out_item_t r;
		pos = st_pos;
		ihl = st_ihl;
		l4 = (st_proto == PROTO_TCP) || (st_proto == PROTO_UDP);
		if (pos == 16'd0) begin
			st_ver = b[7:4];
			st_ihl = hdr_bytes(b[3:0]);
			st_start = st_ihl;
			ihl = st_ihl;
		end else if (pos == POS_PROTOCOL) begin
			st_proto = b;
			if (b == PROTO_TCP)
				st_start = ihl + TCP_MIN_HDR_BYTES;
			else if (b == PROTO_UDP)
				st_start = ihl + UDP_HDR_BYTES;
			else
				st_start = ihl;
		end else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
			st_src = {st_src[23:0], b};
		end else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
			st_dst = {st_dst[23:0], b};
		end
		if (pos >= POS_L4_FIRST && l4) begin
			if (pos == ihl || pos == ihl + 16'd1)
				st_sport = {st_sport[7:0], b};
			else if (pos == ihl + 16'd2 || pos == ihl + 16'd3)
				st_dport = {st_dport[7:0], b};
			else if (st_proto == PROTO_TCP && pos == ihl + TCP_DOFF_OFFSET)
				st_start = ihl + hdr_bytes(b[7:4]);
		end
		pay = (pos >= POS_L4_FIRST) && (pos >= {9'd0, st_start});
		if (pay && st_count != COUNT_MAX)
			st_count = st_count + 16'd1;
		if (st_pos != POS_MAX)
			st_pos = st_pos + 16'd1;
		if (pay || final_mark) begin
			r.payload_valid = pay;
			r.payload_byte = pay ? b : 8'd0;
			r.end_of_packet = final_mark;
			r.ip_version = st_ver;
			r.src_address = st_src;
			r.dst_address = st_dst;
			r.protocol_number = st_proto;
			r.src_port = st_sport;
			r.dst_port = st_dport;
			r.payload_length = st_count;
			r.truncated = final_mark && (st_pos < {9'd0, st_start});
			parsed_due = {parsed_due, r};
		end
		if (final_mark)
			clear_parse_state();
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic report_field(input string name, input logic [31:0] seen, input logic [31:0] due);
		if (seen !== due)
			report_mismatch($sformatf("result %0d %s got %0h want %0h",
				results_seen, name, seen, due));
	endtask

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && parsed_ch.valid && parsed_ch.ready) begin
			results_seen++;
			if (parsed_due.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
			end else begin
				want = parsed_due.pop_front();
				got = parsed_ch.data;
				report_field("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
				report_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
				report_field("end_of_packet", 32'(got.end_of_packet), 32'(want.end_of_packet));
				report_field("ip_version", 32'(got.ip_version), 32'(want.ip_version));
				report_field("src_address", got.src_address, want.src_address);
				report_field("dst_address", got.dst_address, want.dst_address);
				report_field("protocol_number", 32'(got.protocol_number),
					32'(want.protocol_number));
				report_field("src_port", 32'(got.src_port), 32'(want.src_port));
				report_field("dst_port", 32'(got.dst_port), 32'(want.dst_port));
				report_field("payload_length", 32'(got.payload_length),
					32'(want.payload_length));
				report_field("truncated", 32'(got.truncated), 32'(want.truncated));
				if (want.payload_valid)
					payload_results++;
				if (want.truncated)
					trunc_ends++;
			end
		end
	end

	always @(posedge clk) begin
		if ((pkt_bytes_ch.valid && pkt_bytes_ch.ready) || (parsed_ch.valid && parsed_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("ipv4_l4_header_parser_unit verification failed");
			$finish;
		end
	end

	// receiver side: stall at the rate of the current phase
	initial begin
		parsed_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			parsed_ch.ready <= arst_n && ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] value, input logic final_mark);
		in_item_t item;
		item.data_byte = value;
		item.last_byte = final_mark;
		if ($urandom_range(99) < src_idle_pct) begin
			pkt_bytes_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		pkt_bytes_ch.valid <= 1'b1;
		pkt_bytes_ch.data <= item;
		do @(posedge clk); while (!pkt_bytes_ch.ready);
		parse_byte(value, final_mark);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt_buf.size(); i++)
			send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
		packets_sent++;
	endtask

	// random bytes with the version/IHL, protocol and TCP data offset placed
	task automatic make_packet(input logic [7:0] b0, input logic [7:0] proto,
		input logic [7:0] doff, input int total);
		int ihl;
		pkt_buf.delete();
		for (int i = 0; i < total; i++)
			pkt_buf = {pkt_buf, rand_byte()};
		ihl = hdr_bytes(b0[3:0]);
		if (total > 0)
			pkt_buf[0] = b0;
		if (total > POS_PROTOCOL)
			pkt_buf[POS_PROTOCOL] = proto;
		if (proto == PROTO_TCP && total > ihl + TCP_DOFF_OFFSET)
			pkt_buf[ihl + TCP_DOFF_OFFSET] = doff;
	endtask

	task automatic rand_packet();
		int shape;
		int pick;
		int hlen;
		int total;
		logic [7:0] b0;
		logic [7:0] proto;
		logic [7:0] doff;
		logic [7:0] r;
		logic [3:0] ver;
		logic [3:0] words;
		logic [3:0] dwords;
		shape = $urandom_range(99);
		r = rand_byte();
		ver = ($urandom_range(9) == 0) ? r[7:4] : 4'd4;
		words = ($urandom_range(3) == 0) ? r[3:0] : MIN_WORDS;
		b0 = {ver, words};
		r = rand_byte();
		dwords = ($urandom_range(3) == 0) ? r[7:4] : MIN_WORDS;
		doff = {dwords, r[3:0]};
		pick = $urandom_range(99);
		if (pick < 40)
			proto = PROTO_TCP;
		else if (pick < 75)
			proto = PROTO_UDP;
		else
			proto = rand_byte();
		hlen = hdr_bytes(words);
		if (proto == PROTO_TCP)
			hlen += hdr_bytes(dwords);
		else if (proto == PROTO_UDP)
			hlen += UDP_HDR_BYTES;
		if (shape < 70) begin
			total = hlen + $urandom_range(12);
		end else if (shape < 90) begin
			// cut inside the headers, or exactly at their end
			total = $urandom_range(hlen, 1);
		end else begin
			b0 = rand_byte();
			proto = rand_byte();
			doff = rand_byte();
			total = $urandom_range(48, 1);
		end
		make_packet(b0, proto, doff, total);
		send_packet();
	endtask

	task automatic test_header_truncation();
		src_idle_pct = 20;
		sink_stall_pct = 20;
		make_packet(8'hFF, 8'h00, 8'h00, 1);
		send_packet();
		make_packet(8'h45, PROTO_TCP, 8'h00, 10);
		send_packet();
		make_packet(8'h45, PROTO_UDP, 8'h00, 14);
		send_packet();
		make_packet(8'h45, PROTO_UDP, 8'h00, 20);
		send_packet();
		// TCP ends before its data offset byte
		make_packet(8'h45, PROTO_TCP, 8'h50, 30);
		send_packet();
		// data offset byte seen, packet ends inside the longer TCP header
		make_packet(8'h45, PROTO_TCP, 8'h80, 36);
		send_packet();
	endtask

	task automatic test_transport_payload();
		src_idle_pct = 20;
		sink_stall_pct = 20;
		make_packet(8'h40, PROTO_ICMP, 8'h00, 24);
		send_packet();
		make_packet(8'h43, 8'h00, 8'h00, 20);
		send_packet();
		make_packet(8'h4F, PROTO_UDP, 8'h00, 72);
		send_packet();
		make_packet(8'h45, PROTO_UDP, 8'h00, 28);
		send_packet();
		make_packet(8'h45, PROTO_TCP, 8'h20, 44);
		send_packet();
		make_packet(8'h46, PROTO_TCP, 8'hF0, 87);
		send_packet();
		make_packet(8'h45, 8'hFF, 8'h00, 21);
		send_packet();
		make_packet(8'h00, PROTO_TCP, 8'h50, 41);
		send_packet();
		make_packet(8'h45, PROTO_ICMP, 8'h00, 22);
		pkt_buf[20] = 8'h00;
		pkt_buf[21] = 8'hFF;
		send_packet();
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int budget);
		int start;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		start = bytes_sent;
		while (bytes_sent - start < budget)
			rand_packet();
	endtask

	initial begin
		arst_n <= 1'b0;
		pkt_bytes_ch.valid <= 1'b0;
		pkt_bytes_ch.data <= '0;
		clear_parse_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_truncation();
		test_transport_payload();
		test_random_traffic(0, 0, PHASE_BYTES);
		test_random_traffic(59, 0, PHASE_BYTES);
		test_random_traffic(0, 59, PHASE_BYTES);
		test_random_traffic(20, 20, PHASE_BYTES);
		pkt_bytes_ch.valid <= 1'b0;
		while (parsed_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (parsed_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", parsed_due.size()));
		$display("sent %0d packets in %0d bytes: directed header cases, then four random phases",
			packets_sent, bytes_sent);
		$display("checked %0d results: %0d payload bytes, %0d truncated ends, %0d mismatches",
			results_seen, payload_results, trunc_ends, mismatches);
		if (mismatches == 0)
			$display("ipv4_l4_header_parser_unit verification clean");
		else
			$display("ipv4_l4_header_parser_unit verification failed");
		$finish;
	end

endmodule

### sim.f
design/ipv4p_pkg.sv
design/ipv4p_chan_if.sv
design/ipv4p_core.sv
design/ipv4_l4_header_parser_unit.sv
tb/sv/tb_ipv4_l4_header_parser_unit.sv
